// ----- hdl/restoring_unsigned_divider_assert.svh -----
// Assertion macros for the restoring unsigned divider checker
`ifndef RESTORING_UNSIGNED_DIVIDER_ASSERT_SVH
`define RESTORING_UNSIGNED_DIVIDER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, idle in reset
`define RUD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("restoring_unsigned_divider: check failed");

// next-cycle implication, sampled on i_clk, idle in reset
`define RUD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("restoring_unsigned_divider: check failed");

`endif

// ----- hdl/rud_pkg.sv -----
// Shared constants and types for the restoring unsigned divider
`timescale 1ns / 1ps
`default_nettype none
package rud_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int OPND_W         = 32;
    localparam int QUO_W          = 32;

    typedef struct packed {
        logic en;
        logic valid;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ----- hdl/rud_cell.sv -----
// One restoring division step: shift in a dividend bit, trial subtract, emit a quotient bit
`timescale 1ns / 1ps
`default_nettype none
module rud_cell #(
    parameter int DATA_WIDTH = rud_pkg::DATA_WIDTH_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire rud_pkg::t_cell_ctl  i_ctl,
    input  wire  [DATA_WIDTH-1:0]    i_num,
    input  wire  [DATA_WIDTH-1:0]    i_den,
    input  wire  [DATA_WIDTH-1:0]    i_rem,
    input  wire  [DATA_WIDTH-1:0]    i_quo,
    input  wire                      i_started,
    output logic                     o_valid,
    output logic [DATA_WIDTH-1:0]    o_num,
    output logic [DATA_WIDTH-1:0]    o_den,
    output logic [DATA_WIDTH-1:0]    o_rem,
    output logic [DATA_WIDTH-1:0]    o_quo,
    output logic                     o_started
);
    import rud_pkg::*;

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_num, r_den, r_rem, r_quo;
    logic                  r_started;

    logic [DATA_WIDTH-1:0] n_num, n_rem, n_quo;
    logic                  n_started;
    logic [DATA_WIDTH:0]   w_trial, w_diff;
    logic                  w_take;

    always_comb begin
        n_started = i_started | i_num[DATA_WIDTH-1];
        w_trial   = {i_rem, i_num[DATA_WIDTH-1]};
        w_diff    = w_trial - {1'b0, i_den};
        w_take    = n_started && (w_trial >= {1'b0, i_den});
        n_num     = {i_num[DATA_WIDTH-2:0], 1'b0};
        n_quo     = {i_quo[DATA_WIDTH-2:0], w_take};
        if (w_take) begin
            n_rem = w_diff[DATA_WIDTH-1:0];
        end else begin
            n_rem = w_trial[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_num     <= n_num;
            r_den     <= i_den;
            r_rem     <= n_rem;
            r_quo     <= n_quo;
            r_started <= n_started;
        end
    end

    assign o_valid   = r_valid;
    assign o_num     = r_num;
    assign o_den     = r_den;
    assign o_rem     = r_rem;
    assign o_quo     = r_quo;
    assign o_started = r_started;

endmodule
`default_nettype wire

// ----- hdl/restoring_unsigned_divider.sv -----
// Each item passes through the DATA_WIDTH step cells in order, then the result register.
// The chain of DATA_WIDTH step cells carries one item at a time, one quotient bit per cell per
// cycle unless stalled; it stalls while the last cell holds an item and a result waits untaken.
// The result register frees the chain, so a new item is taken while a result waits.
// Reset (synchronous, active low) clears the cell and result valid flags only.
`timescale 1ns / 1ps
`default_nettype none
module restoring_unsigned_divider #(
    parameter int DATA_WIDTH = rud_pkg::DATA_WIDTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    input  wire  [2*rud_pkg::OPND_W-1:0]     i_s_tdata,  // dividend[31:0], divisor[63:32]
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    output logic [rud_pkg::QUO_W-1:0]        o_m_tdata,  // quotient[31:0]
    output logic                             o_m_tuser   // divide_by_zero[0]
);
    import rud_pkg::*;

    logic [DATA_WIDTH:0]   w_valid;
    logic [DATA_WIDTH-1:0] w_num [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] w_den [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] w_rem [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] w_quo [0:DATA_WIDTH];
    logic [DATA_WIDTH:0]   w_started;
    logic                  w_en;
    logic                  w_busy;

    logic                  r_out_valid;
    logic [QUO_W-1:0]      r_quo;
    logic                  r_dbz;

    assign w_busy     = |w_valid[DATA_WIDTH:1];
    assign o_s_tready = !w_busy;
    assign w_en       = !(w_valid[DATA_WIDTH] && r_out_valid && !i_m_tready);

    assign w_valid[0]   = i_s_tvalid && o_s_tready;
    assign w_num[0]     = DATA_WIDTH'(i_s_tdata[OPND_W-1:0]);
    assign w_den[0]     = DATA_WIDTH'(i_s_tdata[2*OPND_W-1:OPND_W]);
    assign w_rem[0]     = '0;
    assign w_quo[0]     = '0;
    assign w_started[0] = 1'b0;

    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_cell
        t_cell_ctl w_ctl;
        assign w_ctl.en    = w_en;
        assign w_ctl.valid = w_valid[g];

        rud_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_num     (w_num[g]),
            .i_den     (w_den[g]),
            .i_rem     (w_rem[g]),
            .i_quo     (w_quo[g]),
            .i_started (w_started[g]),
            .o_valid   (w_valid[g+1]),
            .o_num     (w_num[g+1]),
            .o_den     (w_den[g+1]),
            .o_rem     (w_rem[g+1]),
            .o_quo     (w_quo[g+1]),
            .o_started (w_started[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_valid[DATA_WIDTH] && w_en) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_valid[DATA_WIDTH] && w_en) begin
            r_quo <= QUO_W'(w_quo[DATA_WIDTH]);
            r_dbz <= (w_den[DATA_WIDTH] == '0);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_quo;
    assign o_m_tuser  = r_dbz;

endmodule
`default_nettype wire

// ----- hdl/rud_checker.sv -----
// Port-level checks for the restoring unsigned divider, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "restoring_unsigned_divider_assert.svh"
module rud_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_s_tvalid,
    input wire                          o_s_tready,
    input wire [2*rud_pkg::OPND_W-1:0]  i_s_tdata,
    input wire                          o_m_tvalid,
    input wire                          i_m_tready,
    input wire [rud_pkg::QUO_W-1:0]     o_m_tdata,
    input wire                          o_m_tuser
);
    import rud_pkg::*;

    logic w_in_beat;
    logic w_in_zero;

    assign w_in_beat = i_s_tvalid && o_s_tready;
    assign w_in_zero = (i_s_tdata == '0);

    `RUD_ASSERT_NXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
    `RUD_ASSERT_NXT(a_one_in_flight, w_in_beat && !w_in_zero || w_in_beat, !o_s_tready)
    `RUD_ASSERT_IMP(a_result_after_work, $rose(o_m_tvalid), $past(!o_s_tready))
    `RUD_ASSERT_IMP(a_dbz_ones, o_m_tvalid && o_m_tuser, (o_m_tdata & (o_m_tdata + 32'd1)) == 32'd0)

endmodule

bind restoring_unsigned_divider rud_checker u_rud_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire
